// File: sv/dshtx_pkg.sv
// dshtx_pkg: shared types and constants for the DShot frame transmitter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dshtx_pkg;

	localparam int MAX_MOTORS = 4;
	localparam int VALUE_W    = 11;
	localparam int FRAME_BITS = 16;
	localparam int CSUM_W     = 4;
	localparam int BIT_POS_W  = 5;
	localparam int HIGH_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// item function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TELEMETRY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_ONE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_ZERO  = 2'd2;

	localparam logic [HIGH_W-1:0] HIGH_ONE_RST  = 4'd6;
	localparam logic [HIGH_W-1:0] HIGH_ZERO_RST = 4'd3;

	typedef struct packed {
		logic                               func;
		logic [MAX_MOTORS-1:0][VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic              telemetry;
		logic [HIGH_W-1:0] high_one;
		logic [HIGH_W-1:0] high_zero;
	} cfg_t;

	typedef struct packed {
		logic [MAX_MOTORS-1:0] pins;
		logic                  busy;
		logic                  frame_end;
		logic                  start_rejected;
	} result_t;

endpackage

`default_nettype wire

// File: sv/dshot_frame_transmitter_core.sv
// dshot_frame_transmitter_core: top level of the DShot frame transmitter.
// Depends on dshtx_pkg and dshtx_engine (which uses dshtx_frame_build).
//
// Usage:
//   Input channel (in_valid/in_stall, func, value_0..value_3): func = start
//   loads one frame per motor (11-bit value, telemetry bit, XOR checksum);
//   func = tick emits one sample of every motor pin. A start while a frame or
//   its trailing gap is still going out is dropped and flagged.
//   Output channel (out_valid/out_stall): exactly one result item per input
//   item: pin_levels, busy_res, frame_end, start_rejected.
//   Config port (cfg_we, cfg_index, cfg_data): 0 telemetry request,
//   1 high samples for a one bit, 2 high samples for a zero bit. Write only
//   while idle; index 3 is ignored.
// Timing:
//   An item is registered at acceptance and its result is registered in the
//   output register when stage 1 moves on. One item per cycle sustained while
//   out_stall is low; the limit is the single counter/frame-state update per
//   item in the engine.
// Reset: counters idle, frames zero, registers 0 / 6 / 3, both channels empty.
// Stall: a stalled result holds in the output register; the input register
//   still takes one more item, after which in_stall rises until out_stall
//   drops.
`timescale 1ns / 1ps
`default_nettype none

module dshot_frame_transmitter_core #(
	parameter int MOTOR_COUNT     = 4,
	parameter int SAMPLES_PER_BIT = 8,
	parameter int GAP_SAMPLES     = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// config write port
	input  wire logic                                cfg_we,
	input  wire logic [dshtx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dshtx_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                func,
	input  wire logic [dshtx_pkg::VALUE_W-1:0]       value_0,
	input  wire logic [dshtx_pkg::VALUE_W-1:0]       value_1,
	input  wire logic [dshtx_pkg::VALUE_W-1:0]       value_2,
	input  wire logic [dshtx_pkg::VALUE_W-1:0]       value_3,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [dshtx_pkg::MAX_MOTORS-1:0]    pin_levels,
	output logic                                     busy_res,
	output logic                                     frame_end,
	output logic                                     start_rejected
);

	dshtx_pkg::cfg_t    cfg_q;
	dshtx_pkg::item_t   item_s1;
	logic               valid_s1;
	dshtx_pkg::result_t res;
	dshtx_pkg::result_t out_q;
	logic               out_valid_q;
	logic               adv;
	logic               in_take;

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.telemetry <= 1'b0;
			cfg_q.high_one  <= dshtx_pkg::HIGH_ONE_RST;
			cfg_q.high_zero <= dshtx_pkg::HIGH_ZERO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dshtx_pkg::REG_TELEMETRY: cfg_q.telemetry <= cfg_data[0];
				dshtx_pkg::REG_HIGH_ONE:  cfg_q.high_one  <= cfg_data;
				dshtx_pkg::REG_HIGH_ZERO: cfg_q.high_zero <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- handshake ----
	// stage 1 moves on when the output register is empty or being drained
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	// ---- input register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.func     <= func;
			item_s1.value[0] <= value_0;
			item_s1.value[1] <= value_1;
			item_s1.value[2] <= value_2;
			item_s1.value[3] <= value_3;
		end
	end

	// ---- frame state and sampling ----
	dshtx_engine #(
		.MOTOR_COUNT     (MOTOR_COUNT),
		.SAMPLES_PER_BIT (SAMPLES_PER_BIT),
		.GAP_SAMPLES     (GAP_SAMPLES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign pin_levels     = out_q.pins;
	assign busy_res       = out_q.busy;
	assign frame_end      = out_q.frame_end;
	assign start_rejected = out_q.start_rejected;

	// ---- assertions ----
	// a rejected start only happens while a frame is in flight
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_rejected |-> busy_res)
		else $error("rejected start without busy");

	// the frame ends on the item that leaves the block idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> !busy_res)
		else $error("frame_end while still busy");

	// motors beyond the configured count never toggle
	a_unused_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (4'(pin_levels >> MOTOR_COUNT) == 4'd0))
		else $error("unused motor pin driven");

	// an item in stage 1 that moves on shows up as a result next cycle
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv |=> out_valid)
		else $error("item lost between stages");

endmodule

`default_nettype wire

// File: sv/dshtx_frame_build.sv
// dshtx_frame_build: builds one 16-bit DShot frame (value, telemetry bit, checksum).
// Depends on dshtx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dshtx_frame_build (
	input  wire logic [dshtx_pkg::VALUE_W-1:0]    value,
	input  wire logic                             telemetry,
	output logic      [dshtx_pkg::FRAME_BITS-1:0] frame
);

	logic [dshtx_pkg::VALUE_W:0]       data;
	logic [dshtx_pkg::CSUM_W-1:0]      csum;

	assign data  = {value, telemetry};
	// XOR of the three nibbles
	assign csum  = data[3:0] ^ data[7:4] ^ data[11:8];
	assign frame = {data, csum};

endmodule

`default_nettype wire

// File: sv/dshtx_engine.sv
// dshtx_engine: frame store, bit/sample/gap counters and pin level logic.
// Depends on dshtx_pkg and dshtx_frame_build.
`timescale 1ns / 1ps
`default_nettype none

module dshtx_engine #(
	parameter int MOTOR_COUNT     = 4,
	parameter int SAMPLES_PER_BIT = 8,
	parameter int GAP_SAMPLES     = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire dshtx_pkg::item_t   item,
	input  wire dshtx_pkg::cfg_t    cfg,
	output dshtx_pkg::result_t      res
);

	localparam int SPB_W = $clog2(SAMPLES_PER_BIT);
	localparam int GAP_W = (GAP_SAMPLES > 0) ? $clog2(GAP_SAMPLES + 1) : 1;
	localparam int HW    = dshtx_pkg::HIGH_W;
	localparam int BPW   = dshtx_pkg::BIT_POS_W;
	localparam int FB    = dshtx_pkg::FRAME_BITS;
	localparam int NM    = dshtx_pkg::MAX_MOTORS;
	localparam logic [SPB_W-1:0] SPB_LAST = SPB_W'(SAMPLES_PER_BIT - 1);
	localparam logic [GAP_W-1:0] GAP_INIT = GAP_W'(GAP_SAMPLES);
	localparam logic [BPW-1:0]   LAST_BIT = BPW'(FB - 1);

	logic [FB-1:0]    frame_q [MOTOR_COUNT];
	logic [FB-1:0]    frame_new [MOTOR_COUNT];
	logic [BPW-1:0]   bit_pos_q;
	logic [SPB_W-1:0] sample_pos_q;
	logic [GAP_W-1:0] gap_q;
	logic             active_q;

	logic [BPW-1:0]   bit_pos_d;
	logic [SPB_W-1:0] sample_pos_d;
	logic [GAP_W-1:0] gap_d;
	logic [GAP_W-1:0] gap_dec;
	logic             active_d;
	logic             load;
	logic             is_start;
	logic             data_phase;
	logic [NM-1:0]    pin_raw;
	logic [3:0]       bit_sel;
	logic [HW-1:0]    sample_ext;

	assign is_start   = (item.func == dshtx_pkg::FUNC_START);
	assign data_phase = (bit_pos_q < BPW'(FB));
	assign bit_sel    = ~bit_pos_q[3:0];    // MSB first
	assign sample_ext = HW'(sample_pos_q);
	assign gap_dec    = (gap_q != '0) ? gap_q - GAP_W'(1) : gap_q;

	genvar m;
	generate
		for (m = 0; m < NM; m++) begin : g_motor
			if (m < MOTOR_COUNT) begin : g_on
				logic [HW-1:0] high_cnt;

				dshtx_frame_build u_build (
					.value     (item.value[m]),
					.telemetry (cfg.telemetry),
					.frame     (frame_new[m])
				);

				assign high_cnt   = frame_q[m][bit_sel] ? cfg.high_one : cfg.high_zero;
				assign pin_raw[m] = (sample_ext < high_cnt);

				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						frame_q[m] <= '0;
					end else if (load) begin
						frame_q[m] <= frame_new[m];
					end
				end
			end else begin : g_off
				assign pin_raw[m] = 1'b0;
			end
		end
	endgenerate

	always_comb begin
		bit_pos_d          = bit_pos_q;
		sample_pos_d       = sample_pos_q;
		gap_d              = gap_q;
		active_d           = active_q;
		load               = 1'b0;
		res.pins           = '0;
		res.frame_end      = 1'b0;
		res.start_rejected = 1'b0;
		if (is_start) begin
			if (active_q) begin
				res.start_rejected = 1'b1;
			end else begin
				load         = 1'b1;
				bit_pos_d    = '0;
				sample_pos_d = '0;
				gap_d        = GAP_INIT;
				active_d     = 1'b1;
			end
		end else if (active_q) begin
			if (data_phase) begin
				res.pins = pin_raw;
				if (sample_pos_q == SPB_LAST) begin
					sample_pos_d = '0;
					bit_pos_d    = bit_pos_q + BPW'(1);
					if (bit_pos_q == LAST_BIT && gap_q == '0) begin
						active_d      = 1'b0;
						res.frame_end = 1'b1;
					end
				end else begin
					sample_pos_d = sample_pos_q + SPB_W'(1);
				end
			end else begin
				gap_d = gap_dec;
				if (gap_dec == '0) begin
					active_d      = 1'b0;
					res.frame_end = 1'b1;
				end
			end
		end
		res.busy = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q    <= '0;
			sample_pos_q <= '0;
			gap_q        <= '0;
			active_q     <= 1'b0;
		end else if (step) begin
			bit_pos_q    <= bit_pos_d;
			sample_pos_q <= sample_pos_d;
			gap_q        <= gap_d;
			active_q     <= active_d;
		end
	end

endmodule

`default_nettype wire
